/* rtl/core/evdfr_pkg.sv */
// ----------------------------------------------------------------------------
// evdfr_pkg
// Shared types and constants of the detector event frame deframer.
// ----------------------------------------------------------------------------
package evdfr_pkg;

  // frame words are repacked to this width
  localparam int FRAME_W = 40;
  localparam int HELD_W  = 6;

  // header, trailer and frame header patterns
  localparam logic [27:0] EVT_HDR_PATTERN = 28'hC3A3C3A;
  localparam logic [5:0]  EVT_TRL_PATTERN = 6'hB;
  localparam logic [15:0] FRM_HDR_PATTERN = 16'h3C5C;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_HIT     = 3'd1,
    KIND_TRAILER = 3'd2,
    KIND_BAD_HDR = 3'd3,
    KIND_BAD_TRL = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_BODY   = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  chip_index;
    logic [7:0]  l1_count;
    logic [1:0]  early_amp;
    logic [3:0]  column;
    logic [3:0]  row;
    logic [9:0]  arrival_time;
    logic [8:0]  over_threshold;
    logic [9:0]  calibration;
    logic [3:0]  chip_mask;
    logic [31:0] event_info;
  } result_t;

endpackage

/* rtl/core/evdfr_core.sv */
// ----------------------------------------------------------------------------
// evdfr_core
// Event parser: header check, body repacking into 40-bit frame words,
// frame word classification and trailer check. One word per cycle while take is high.
// ----------------------------------------------------------------------------
module evdfr_core
  import evdfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [31:0] word,
  input  logic        last,
  output logic        res_valid,
  output result_t     res
);

  phase_t              phase, phase_next;
  logic [FRAME_W-1:0]  bit_store, bit_store_next;
  logic [HELD_W-1:0]   bits_held, bits_held_next;
  logic [7:0]          latched_l1, latched_l1_next;
  logic [7:0]          chip_counter, chip_counter_next;
  logic [3:0]          held_mask, held_mask_next;

  // repacking datapath
  logic [HELD_W-1:0]         need;
  logic [HELD_W-1:0]         rest_wide;
  logic [4:0]                rest;
  logic [FRAME_W+31:0]       shifted;
  logic [FRAME_W-1:0]        full;
  logic [31:0]               keep;
  logic                      completes;
  logic                      is_frm_hdr;
  logic                      is_hit;
  logic                      hdr_ok;
  logic                      trl_ok;

  assign need      = HELD_W'(FRAME_W) - bits_held;
  assign rest_wide = bits_held - HELD_W'(8);
  assign rest      = rest_wide[4:0];
  assign shifted   = {32'b0, bit_store} << need;
  assign full      = shifted[FRAME_W-1:0] | {8'b0, (word >> rest)};
  assign keep      = word & ((32'h1 << rest) - 32'h1);
  assign completes = (bits_held >= HELD_W'(8));
  assign is_frm_hdr = (full[39:24] == FRM_HDR_PATTERN);
  assign is_hit     = full[39];
  assign hdr_ok     = (word[31:4] == EVT_HDR_PATTERN);
  assign trl_ok     = (word[31:26] == EVT_TRL_PATTERN);

  // next state
  always_comb begin
    phase_next        = phase;
    bit_store_next    = bit_store;
    bits_held_next    = bits_held;
    latched_l1_next   = latched_l1;
    chip_counter_next = chip_counter;
    held_mask_next    = held_mask;
    unique case (phase)
      PH_FIRST: begin
        if (!hdr_ok) begin
          phase_next = last ? PH_FIRST : PH_SKIP;
        end else begin
          held_mask_next    = word[3:0];
          bit_store_next    = '0;
          bits_held_next    = '0;
          latched_l1_next   = '0;
          chip_counter_next = '0;
          phase_next        = last ? PH_FIRST : PH_SECOND;
        end
      end
      PH_SECOND: begin
        phase_next = last ? PH_FIRST : PH_BODY;
      end
      PH_BODY: begin
        if (last) begin
          phase_next = PH_FIRST;
        end else if (completes) begin
          bit_store_next = {8'b0, keep};
          bits_held_next = rest_wide;
          if (is_frm_hdr) begin
            latched_l1_next = full[21:14];
          end else if (!is_hit) begin
            chip_counter_next = chip_counter + 8'd1;
          end
        end else begin
          bit_store_next = {bit_store[7:0], word};
          bits_held_next = bits_held + HELD_W'(32);
        end
      end
      PH_SKIP: begin
        if (last) phase_next = PH_FIRST;
      end
      default: phase_next = PH_FIRST;
    endcase
  end

  // result word
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    res.kind  = KIND_HEADER;
    unique case (phase)
      PH_FIRST: begin
        if (!hdr_ok) begin
          res_valid = 1'b1;
          res.kind  = KIND_BAD_HDR;
        end else if (last) begin
          res_valid = 1'b1;
          res.kind  = KIND_BAD_TRL;
        end
      end
      PH_SECOND: begin
        res_valid = 1'b1;
        if (last) begin
          res.kind = KIND_BAD_TRL;
        end else begin
          res.kind       = KIND_HEADER;
          res.chip_index = chip_counter;
          res.l1_count   = latched_l1;
          res.chip_mask  = held_mask;
          res.event_info = word;
        end
      end
      PH_BODY: begin
        if (last) begin
          res_valid = 1'b1;
          if (trl_ok) begin
            res.kind       = KIND_TRAILER;
            res.chip_index = chip_counter;
            res.l1_count   = latched_l1;
            res.chip_mask  = held_mask;
            res.event_info = word;
          end else begin
            res.kind = KIND_BAD_TRL;
          end
        end else if (completes && !is_frm_hdr && is_hit) begin
          res_valid          = 1'b1;
          res.kind           = KIND_HIT;
          res.chip_index     = chip_counter;
          res.l1_count       = latched_l1;
          res.chip_mask      = held_mask;
          res.early_amp      = full[38:37];
          res.column         = full[36:33];
          res.row            = full[32:29];
          res.arrival_time   = full[28:19];
          res.over_threshold = full[18:10];
          res.calibration    = full[9:0];
        end
      end
      PH_SKIP: begin
        res_valid = 1'b0;
      end
      default: res_valid = 1'b0;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_FIRST;
      bit_store    <= '0;
      bits_held    <= '0;
      latched_l1   <= '0;
      chip_counter <= '0;
      held_mask    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      bit_store    <= bit_store_next;
      bits_held    <= bits_held_next;
      latched_l1   <= latched_l1_next;
      chip_counter <= chip_counter_next;
      held_mask    <= held_mask_next;
    end
  end

endmodule

/* rtl/core/detector_event_frame_deframer_top.sv */
// ----------------------------------------------------------------------------
// detector_event_frame_deframer_top
// Deframes detector events into header, hit and trailer results.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  input    | in        | in_valid / in_ready  | word, last
//  output   | out       | out_valid / out_ready| result_kind .. event_info
//
//  one input word per cycle while in_ready is high; a result is registered
//  in the output register once its word is accepted, or in the skid
//  register first while the output stalls. a two-entry output buffer
//  (output register plus skid register) keeps input flowing through an output
//  stall until the skid register fills; in_ready drops only while it holds a word.
//  rst is synchronous and returns the parser to expecting an event header.
// ----------------------------------------------------------------------------
module detector_event_frame_deframer_top
  import evdfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] word,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  result_kind,
  output logic [7:0]  chip_index,
  output logic [7:0]  l1_count,
  output logic [1:0]  early_amp,
  output logic [3:0]  column,
  output logic [3:0]  row,
  output logic [9:0]  arrival_time,
  output logic [8:0]  over_threshold,
  output logic [9:0]  calibration,
  output logic [3:0]  chip_mask,
  output logic [31:0] event_info
);

  logic    take;
  logic    res_valid;
  result_t res;
  logic    o_valid, s_valid;
  result_t o_res, s_res;
  logic    push;

  assign in_ready = !s_valid;
  assign take     = in_valid && in_ready;
  assign push     = take && res_valid;

  evdfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .word      (word),
    .last      (last),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register and skid register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!o_valid || out_ready) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        s_valid <= 1'b0;
      end else begin
        o_valid <= push;
      end
    end else if (push) begin
      s_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!o_valid || out_ready) begin
      if (s_valid) begin
        o_res <= s_res;
      end else if (push) begin
        o_res <= res;
      end
    end else if (push) begin
      s_res <= res;
    end
  end

  assign out_valid      = o_valid;
  assign result_kind    = o_res.kind;
  assign chip_index     = o_res.chip_index;
  assign l1_count       = o_res.l1_count;
  assign early_amp      = o_res.early_amp;
  assign column         = o_res.column;
  assign row            = o_res.row;
  assign arrival_time   = o_res.arrival_time;
  assign over_threshold = o_res.over_threshold;
  assign calibration    = o_res.calibration;
  assign chip_mask      = o_res.chip_mask;
  assign event_info     = o_res.event_info;

  // skid register only fills behind a full output register
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    s_valid |-> o_valid)
    else $error("skid register holds a word while output register is empty");

  // error results carry no event context
  a_err_fields_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_BAD_HDR || result_kind == KIND_BAD_TRL)
      |-> (chip_index == 8'd0 && l1_count == 8'd0 && chip_mask == 4'd0
           && event_info == 32'd0))
    else $error("error result carries nonzero context fields");

  // hit fields only on hit results
  a_hit_fields_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != KIND_HIT
      |-> (early_amp == 2'd0 && column == 4'd0 && row == 4'd0
           && arrival_time == 10'd0 && over_threshold == 9'd0
           && calibration == 10'd0))
    else $error("non-hit result carries hit fields");

endmodule
